>>> design/sleep_wakeup_timer_table_core_defines.svh
// Assertion macros shared by the sleep/wake-up timer checker.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef SLEEP_WAKEUP_TIMER_TABLE_CORE_DEFINES_SVH
`define SLEEP_WAKEUP_TIMER_TABLE_CORE_DEFINES_SVH

// same-cycle implication
`define SWT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SWT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/swt_pkg.sv
// Types and constants for the sleep/wake-up timer table.
// Used by the front, queue, back, top level and checker.
`default_nettype none

package swt_pkg;

    localparam int TICK_RATE_W  = 21;
    localparam int PID_W        = 16;
    localparam int AMOUNT_W     = 32;
    localparam int KIND_W       = 3;
    localparam int COUNT_W      = 64;
    localparam int PROD_W       = AMOUNT_W + TICK_RATE_W;
    localparam int DIVD_W       = 56;
    localparam int PRE_SHIFT    = 6;
    localparam int DIV_SRC_W    = PROD_W - PRE_SHIFT;
    localparam int MUL_PART_W   = 24;
    localparam int RECIP_W      = 2 * MUL_PART_W;
    localparam int RECIP_SHIFT  = 61;
    localparam int ACC_W        = DIV_SRC_W + RECIP_W;
    localparam int DIV_STEPS    = 4;
    localparam int STEP_W       = $clog2(DIV_STEPS);
    localparam int REM_W        = 20;
    localparam int Q_DEPTH      = 4;
    localparam int Q_AW         = $clog2(Q_DEPTH);

    localparam logic [REM_W-1:0]       USEC_PER_SEC  = REM_W'(1000000);
    localparam logic [TICK_RATE_W-1:0] TICK_RATE_RST = TICK_RATE_W'(18);
    // x / 1000000 == ((x >> 6) * USEC_RECIP) >> 61, exact for any x below 2^53
    localparam logic [RECIP_W-1:0]     USEC_RECIP    = 48'd147573952589677;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_TICKS = 2'd1,
        ACT_SEC   = 2'd2,
        ACT_USEC  = 2'd3
    } action_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_WOKEN    = 3'd0,
        KIND_ACCEPTED = 3'd1,
        KIND_ZERO     = 3'd2,
        KIND_FULL     = 3'd3,
        KIND_NONE     = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_SLEEP = 2'd1,
        OP_ZERO  = 2'd2
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [PID_W-1:0]  proc_id;
        logic [PROD_W-1:0] wait_ticks;
    } q_entry_t;

endpackage

`default_nettype wire

>>> design/swt_front.sv
// Front end: accepts transactions, converts waits to ticks and classifies them.
// Holds the tick rate register; depends on swt_pkg.
`default_nettype none

module swt_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    action,
    input  logic [swt_pkg::PID_W-1:0]     proc_id,
    input  logic [swt_pkg::AMOUNT_W-1:0]  amount,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [swt_pkg::TICK_RATE_W-1:0] cfg_data,
    output logic                          q_push,
    input  logic                          q_full,
    output swt_pkg::q_entry_t             q_entry
);
    import swt_pkg::*;

    typedef enum logic [3:0] {
        F_IDLE = 4'b0001,
        F_MUL  = 4'b0010,
        F_DIV  = 4'b0100,
        F_PUSH = 4'b1000
    } fstate_t;

    fstate_t                 state_reg, state_next;
    logic [1:0]              act_reg, act_next;
    logic [PID_W-1:0]        pid_reg, pid_next;
    logic [AMOUNT_W-1:0]     amt_reg, amt_next;
    logic [DIVD_W-1:0]       dq_reg, dq_next;
    logic [ACC_W-1:0]        acc_reg, acc_next;
    logic [STEP_W-1:0]       step_reg, step_next;
    logic [TICK_RATE_W-1:0]  rate_reg;
    logic [PROD_W-1:0]       product;
    logic [DIV_SRC_W-1:0]    div_src;
    logic [MUL_PART_W-1:0]   a_part;
    logic [MUL_PART_W-1:0]   m_part;
    logic [RECIP_W-1:0]      part;
    logic [ACC_W-1:0]        part_shifted;
    logic [ACC_W-1:0]        acc_sum;

    assign cfg_ready = 1'b1;
    assign product   = amt_reg * rate_reg;
    assign in_stall  = (state_reg != F_IDLE);

    // one 24 x 24 partial product of (product >> 6) * USEC_RECIP per cycle
    assign div_src = dq_reg[PROD_W-1:PRE_SHIFT];
    assign a_part  = step_reg[1] ? MUL_PART_W'(div_src[DIV_SRC_W-1:MUL_PART_W])
                                 : div_src[MUL_PART_W-1:0];
    assign m_part  = step_reg[0] ? USEC_RECIP[RECIP_W-1:MUL_PART_W]
                                 : USEC_RECIP[MUL_PART_W-1:0];
    assign part    = a_part * m_part;
    assign acc_sum = acc_reg + part_shifted;

    always_comb
    begin
        case (step_reg)
            2'd0:    part_shifted = ACC_W'(part);
            2'd3:    part_shifted = ACC_W'(part) << (2 * MUL_PART_W);
            default: part_shifted = ACC_W'(part) << MUL_PART_W;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        act_next   = act_reg;
        pid_next   = pid_reg;
        amt_next   = amt_reg;
        dq_next    = dq_reg;
        acc_next   = acc_reg;
        step_next  = step_reg;
        q_push     = 1'b0;
        q_entry.proc_id    = pid_reg;
        q_entry.wait_ticks = dq_reg[PROD_W-1:0];
        if (act_reg == ACT_TICK)
            q_entry.op = OP_TICK;
        else if (act_reg == ACT_USEC && dq_reg[PROD_W-1:0] == '0)
            q_entry.op = OP_ZERO;
        else
            q_entry.op = OP_SLEEP;
        unique case (state_reg)
            F_IDLE:
            begin
                if (in_valid)
                begin
                    act_next = action;
                    pid_next = proc_id;
                    amt_next = amount;
                    dq_next  = DIVD_W'(amount);
                    if (action == ACT_TICK || action == ACT_TICKS)
                        state_next = F_PUSH;
                    else
                        state_next = F_MUL;
                end
            end
            F_MUL:
            begin
                dq_next   = DIVD_W'(product);
                acc_next  = '0;
                step_next = '0;
                state_next = (act_reg == ACT_SEC) ? F_PUSH : F_DIV;
            end
            F_DIV:
            begin
                acc_next  = acc_sum;
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    dq_next    = DIVD_W'(acc_sum[ACC_W-1:RECIP_SHIFT]);
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (!q_full)
                begin
                    q_push     = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            rate_reg  <= TICK_RATE_RST;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
                rate_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg  <= act_next;
        pid_reg  <= pid_next;
        amt_reg  <= amt_next;
        dq_reg   <= dq_next;
        acc_reg  <= acc_next;
        step_reg <= step_next;
    end

endmodule

`default_nettype wire

>>> design/swt_fifo.sv
// Short queue between the front end and the table engine.
// Depends on swt_pkg for the entry type and depth.
`default_nettype none

module swt_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  swt_pkg::q_entry_t push_entry,
    output logic              full,
    input  logic              pop,
    output logic              pop_valid,
    output swt_pkg::q_entry_t pop_entry
);
    import swt_pkg::*;

    q_entry_t          store_reg [Q_DEPTH];
    logic [Q_AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [Q_AW:0]     cnt_reg;

    assign full      = (cnt_reg == (Q_AW+1)'(Q_DEPTH));
    assign pop_valid = (cnt_reg != '0);
    assign pop_entry = store_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            store_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

`default_nettype wire

>>> design/swt_back.sv
// Table engine: tick counter, sleeper table memory, wake scan and output register.
// Depends on swt_pkg.
`default_nettype none

module swt_back #(
    parameter int SLOTS = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      q_valid,
    input  swt_pkg::q_entry_t         q_entry,
    output logic                      q_pop,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [swt_pkg::KIND_W-1:0] kind,
    output logic [swt_pkg::PID_W-1:0] woken_id,
    output logic                      last
);
    import swt_pkg::*;

    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(SLOTS);

    typedef enum logic [2:0] {
        B_IDLE = 3'b001,
        B_SCAN = 3'b010,
        B_FIN  = 3'b100
    } bstate_t;

    bstate_t              state_reg, state_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]     fill_reg, fill_next;
    logic [CNT_W-1:0]     scan_reg, scan_next;
    logic [CNT_W-1:0]     keep_reg, keep_next;
    logic [CNT_W-1:0]     scan_inc;
    logic                 pend_valid_reg, pend_valid_next;
    logic [PID_W-1:0]     pend_id_reg, pend_id_next;
    logic                 out_valid_reg, out_valid_next;
    kind_t                out_kind_reg;
    logic [PID_W-1:0]     out_id_reg;
    logic                 out_last_reg;

    logic [PID_W-1:0]     proc_mem [SLOTS];
    logic [COUNT_W-1:0]   dl_mem [SLOTS];
    logic [PID_W-1:0]     rd_proc_reg;
    logic [COUNT_W-1:0]   rd_dl_reg;
    logic [AW-1:0]        rd_addr;

    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [PID_W-1:0]     wr_proc;
    logic [COUNT_W-1:0]   wr_dl;

    logic                 out_free;
    logic                 emit;
    kind_t                emit_kind;
    logic [PID_W-1:0]     emit_id;
    logic                 emit_last;
    logic                 advance;

    assign out_free  = !out_valid_reg || !out_stall;
    assign scan_inc  = scan_reg + 1'b1;
    assign rd_addr   = scan_next[AW-1:0];
    assign out_valid = out_valid_reg;
    assign kind      = out_kind_reg;
    assign woken_id  = out_id_reg;
    assign last      = out_last_reg;

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        fill_next       = fill_reg;
        scan_next       = scan_reg;
        keep_next       = keep_reg;
        pend_valid_next = pend_valid_reg;
        pend_id_next    = pend_id_reg;
        q_pop           = 1'b0;
        wr_en           = 1'b0;
        wr_addr         = fill_reg[AW-1:0];
        wr_proc         = q_entry.proc_id;
        wr_dl           = count_reg + COUNT_W'(q_entry.wait_ticks);
        emit            = 1'b0;
        emit_kind       = KIND_NONE;
        emit_id         = '0;
        emit_last       = 1'b1;
        advance         = 1'b0;
        unique case (state_reg)
            B_IDLE:
            begin
                scan_next = '0;
                if (q_valid)
                begin
                    unique case (q_entry.op)
                        OP_TICK:
                        begin
                            q_pop           = 1'b1;
                            count_next      = count_reg + COUNT_W'(1);
                            keep_next       = '0;
                            pend_valid_next = 1'b0;
                            state_next      = (fill_reg == '0) ? B_FIN : B_SCAN;
                        end
                        OP_SLEEP:
                        begin
                            if (out_free)
                            begin
                                q_pop   = 1'b1;
                                emit    = 1'b1;
                                emit_id = q_entry.proc_id;
                                if (fill_reg == SLOTS_C)
                                begin
                                    emit_kind = KIND_FULL;
                                end
                                else
                                begin
                                    emit_kind = KIND_ACCEPTED;
                                    wr_en     = 1'b1;
                                    fill_next = fill_reg + 1'b1;
                                end
                            end
                        end
                        OP_ZERO:
                        begin
                            if (out_free)
                            begin
                                q_pop     = 1'b1;
                                emit      = 1'b1;
                                emit_kind = KIND_ZERO;
                                emit_id   = q_entry.proc_id;
                            end
                        end
                        default:
                        begin
                            q_pop = 1'b1;
                        end
                    endcase
                end
            end
            B_SCAN:
            begin
                if (rd_dl_reg <= count_reg)
                begin
                    // hold one due sleeper back so the final report can carry last
                    if (!pend_valid_reg || out_free)
                    begin
                        advance         = 1'b1;
                        emit            = pend_valid_reg;
                        emit_kind       = KIND_WOKEN;
                        emit_id         = pend_id_reg;
                        emit_last       = 1'b0;
                        pend_valid_next = 1'b1;
                        pend_id_next    = rd_proc_reg;
                    end
                end
                else
                begin
                    advance   = 1'b1;
                    wr_en     = 1'b1;
                    wr_addr   = keep_reg[AW-1:0];
                    wr_proc   = rd_proc_reg;
                    wr_dl     = rd_dl_reg;
                    keep_next = keep_reg + 1'b1;
                end
                if (advance)
                begin
                    scan_next = scan_inc;
                    if (scan_inc == fill_reg)
                        state_next = B_FIN;
                end
            end
            B_FIN:
            begin
                if (out_free)
                begin
                    emit            = 1'b1;
                    emit_kind       = pend_valid_reg ? KIND_WOKEN : KIND_NONE;
                    emit_id         = pend_valid_reg ? pend_id_reg : '0;
                    emit_last       = 1'b1;
                    pend_valid_next = 1'b0;
                    fill_next       = keep_reg;
                    state_next      = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
        if (emit)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= B_IDLE;
            count_reg      <= '0;
            fill_reg       <= '0;
            scan_reg       <= '0;
            keep_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            fill_reg       <= fill_next;
            scan_reg       <= scan_next;
            keep_reg       <= keep_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_id_reg <= pend_id_next;
        if (emit)
        begin
            out_kind_reg <= emit_kind;
            out_id_reg   <= emit_id;
            out_last_reg <= emit_last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            proc_mem[wr_addr] <= wr_proc;
            dl_mem[wr_addr]   <= wr_dl;
        end
        rd_proc_reg <= proc_mem[rd_addr];
        rd_dl_reg   <= dl_mem[rd_addr];
    end

endmodule

`default_nettype wire

>>> design/sleep_wakeup_timer_table_core.sv
// Sleep/wake-up timer table, top level.
// Instantiates swt_front, swt_fifo and swt_back; depends on swt_pkg.
//
// Keeps a 64-bit tick counter and an oldest-first table of up to SLOTS sleepers.
// Each input transaction is either a tick or a sleep request (wait in ticks, seconds or
// microseconds); each produces one or more result transactions, the final one marked
// by last. The front end takes one transaction at a time: ticks and tick waits go
// straight to the queue push, second waits pass the multiply by the tick rate, and
// microsecond waits also the divide by one million, done as a multiply by a 48-bit
// reciprocal in four 24 x 24 partial products, one per cycle. A 4-entry queue
// decouples it from the table engine, which answers a sleep request once its output
// register is free and scans the n stored sleepers of a tick with one table memory
// read per cycle, held while the output side stalls. The tick rate register is written
// through the cfg port, which is always ready, and must only be written while idle.
`default_nettype none

module sleep_wakeup_timer_table_core #(
    parameter int SLOTS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [1:0]                       action,
    input  logic [swt_pkg::PID_W-1:0]        proc_id,
    input  logic [swt_pkg::AMOUNT_W-1:0]     amount,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [swt_pkg::KIND_W-1:0]       kind,
    output logic [swt_pkg::PID_W-1:0]        woken_id,
    output logic                             last,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [swt_pkg::TICK_RATE_W-1:0]  cfg_data
);
    import swt_pkg::*;

    logic     q_push;
    logic     q_full;
    logic     q_pop;
    logic     q_valid;
    q_entry_t q_push_entry;
    q_entry_t q_pop_entry;

    swt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .action    (action),
        .proc_id   (proc_id),
        .amount    (amount),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .q_push    (q_push),
        .q_full    (q_full),
        .q_entry   (q_push_entry)
    );

    swt_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .pop_valid  (q_valid),
        .pop_entry  (q_pop_entry)
    );

    swt_back #(
        .SLOTS (SLOTS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_entry   (q_pop_entry),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .kind      (kind),
        .woken_id  (woken_id),
        .last      (last)
    );

endmodule

`default_nettype wire

>>> design/swt_props.sv
// Port-level checks for the sleep/wake-up timer table, bound to the top level.
// Depends on swt_pkg and sleep_wakeup_timer_table_core_defines.svh.
`default_nettype none
`include "sleep_wakeup_timer_table_core_defines.svh"

module swt_props (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_stall,
    input  logic                         out_valid,
    input  logic                         out_stall,
    input  logic [swt_pkg::KIND_W-1:0]   kind,
    input  logic [swt_pkg::PID_W-1:0]    woken_id,
    input  logic                         last
);
    import swt_pkg::*;

    `SWT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(kind) && $stable(woken_id) && $stable(last), "stalled result changed")
    `SWT_ASSERT_SAME(a_single_last, out_valid && kind != KIND_WOKEN, last, "non-wake result without last")
    `SWT_ASSERT_SAME(a_none_id, out_valid && kind == KIND_NONE, woken_id == '0, "empty tick report with nonzero id")
    `SWT_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "front took two transactions back to back")

endmodule

bind sleep_wakeup_timer_table_core swt_props u_props (.*);

`default_nettype wire

>>> verif/tb_sleep_wakeup_timer_table_core.sv
// Self-checking testbench for sleep_wakeup_timer_table_core.
// Drives ticks and sleep requests, predicts every report in a scoreboard class.
// Depends on swt_pkg and the design files only.
`timescale 1ns / 100ps

module tb_sleep_wakeup_timer_table_core;
    import swt_pkg::*;

    localparam int SLOTS           = 16;
    localparam int HOLD_CYCLES     = 300;
    localparam int SETTLE_CYCLES   = 40;
    localparam int ITEMS_PER_PHASE = 34;
    localparam int MAX_SHOWN       = 10;
    localparam int RATE_MAX        = 1193180;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [PID_W-1:0]  id;
        logic              last;
    } report_t;

    class sleep_table_scoreboard;
        logic [TICK_RATE_W-1:0] rate;
        logic [COUNT_W-1:0]     ticks;
        logic [PID_W-1:0]       sleeper_pid[$];
        logic [COUNT_W-1:0]     sleeper_due[$];
        report_t                expected_reports[$];
        int                     mismatches;
        int                     requests;
        int                     kind_seen[5];

        function new();
            rate       = TICK_RATE_RST;
            ticks      = '0;
            mismatches = 0;
            requests   = 0;
            foreach (kind_seen[k])
                kind_seen[k] = 0;
        endfunction

        function void set_rate(logic [TICK_RATE_W-1:0] value);
            rate = value;
        endfunction

        function int pending();
            return expected_reports.size();
        endfunction

        function void push_report(kind_t k, logic [PID_W-1:0] id, logic fin);
            report_t r;
            r.kind = k;
            r.id   = id;
            r.last = fin;
            expected_reports.push_back(r);
        endfunction

        function void note_request(action_t act, logic [PID_W-1:0] pid,
                                   logic [AMOUNT_W-1:0] amt);
            logic [COUNT_W-1:0] product;
            logic [COUNT_W-1:0] wait_ticks;
            logic [PID_W-1:0]   woken[$];
            logic [PID_W-1:0]   kept_pid[$];
            logic [COUNT_W-1:0] kept_due[$];
            requests++;
            if (act == ACT_TICK)
            begin
                ticks = ticks + 1;
                foreach (sleeper_pid[i])
                begin
                    if (sleeper_due[i] <= ticks)
                        woken.push_back(sleeper_pid[i]);
                    else
                    begin
                        kept_pid.push_back(sleeper_pid[i]);
                        kept_due.push_back(sleeper_due[i]);
                    end
                end
                sleeper_pid = kept_pid;
                sleeper_due = kept_due;
                if (woken.size() == 0)
                    push_report(KIND_NONE, '0, 1'b1);
                foreach (woken[i])
                    push_report(KIND_WOKEN, woken[i], i == woken.size() - 1);
                return;
            end
            product = COUNT_W'(amt) * COUNT_W'(rate);
            case (act)
                ACT_TICKS: wait_ticks = COUNT_W'(amt);
                ACT_SEC:   wait_ticks = product;
                default:   wait_ticks = product / COUNT_W'(USEC_PER_SEC);
            endcase
            if (act == ACT_USEC && wait_ticks == 0)
                push_report(KIND_ZERO, pid, 1'b1);
            else if (sleeper_pid.size() >= SLOTS)
                push_report(KIND_FULL, pid, 1'b1);
            else
            begin
                sleeper_pid.push_back(pid);
                sleeper_due.push_back(ticks + wait_ticks);
                push_report(KIND_ACCEPTED, pid, 1'b1);
            end
        endfunction

        function void check_report(logic [KIND_W-1:0] k, logic [PID_W-1:0] id, logic fin);
            report_t want;
            if (k < 5)
                kind_seen[k]++;
            if (expected_reports.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("%0t: unexpected report kind %0d id %h last %b",
                             $realtime, k, id, fin);
                return;
            end
            want = expected_reports.pop_front();
            if (want.kind !== k || want.id !== id || want.last !== fin)
            begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("%0t: report mismatch: expected kind %0d id %h last %b, got kind %0d id %h last %b",
                             $realtime, want.kind, want.id, want.last, k, id, fin);
            end
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic [1:0]             action;
    logic [PID_W-1:0]       proc_id;
    logic [AMOUNT_W-1:0]    amount;
    logic                   out_valid;
    logic                   out_stall;
    logic [KIND_W-1:0]      kind;
    logic [PID_W-1:0]       woken_id;
    logic                   last;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [TICK_RATE_W-1:0] cfg_data;

    sleep_table_scoreboard sb;
    bit                    no_idle;
    bit                    hold_req;
    int                    hold_left;

    sleep_wakeup_timer_table_core #(
        .SLOTS(SLOTS)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .action   (action),
        .proc_id  (proc_id),
        .amount   (amount),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .kind     (kind),
        .woken_id (woken_id),
        .last     (last),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #3_000_000;
        $display("tb_sleep_wakeup_timer_table_core: FAIL");
        $finish;
    end

    // result side: random stalls plus one long hold-off on request
    initial
    begin
        out_stall = 1'b0;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= !no_idle && ($urandom_range(99) < 11);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_report(kind, woken_id, last);
    end

    task automatic send_request(action_t act, logic [PID_W-1:0] pid,
                                logic [AMOUNT_W-1:0] amt);
        while (!no_idle && $urandom_range(99) < 11)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        action   <= act;
        proc_id  <= pid;
        amount   <= amt;
        do @(posedge clk); while (in_stall);
        sb.note_request(act, pid, amt);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_rate(logic [TICK_RATE_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        sb.set_rate(value);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // mostly short waits so the table keeps turning over; zero rate allows any amount
    task automatic send_random(logic [TICK_RATE_W-1:0] rate);
        action_t             act;
        logic [PID_W-1:0]    pid;
        logic [AMOUNT_W-1:0] amt;
        logic [COUNT_W-1:0]  scaled;
        int                  target;
        pid    = ($urandom_range(99) < 20) ? PID_W'($urandom_range(3)) : PID_W'($urandom);
        target = $urandom_range(10);
        amt    = $urandom;
        if ($urandom_range(99) < 35)
            act = ACT_TICK;
        else
        begin
            act = action_t'($urandom_range(3, 1));
            if (act == ACT_TICKS)
                amt = AMOUNT_W'(target);
            else if (rate != 0 && act == ACT_SEC)
                amt = (rate > 10) ? '0 : AMOUNT_W'($urandom_range(10 / rate));
            else if (rate != 0)
            begin
                scaled = COUNT_W'(target) * COUNT_W'(USEC_PER_SEC)
                         + COUNT_W'($urandom_range(999999));
                scaled = scaled / COUNT_W'(rate);
                amt    = scaled[AMOUNT_W-1:0];
            end
        end
        send_request(act, pid, amt);
    endtask

    initial
    begin
        logic [TICK_RATE_W-1:0] phase_rate[4];
        sb        = new();
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        action    = '0;
        proc_id   = '0;
        amount    = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        no_idle   = 1'b0;
        hold_req  = 1'b0;
        phase_rate[0] = TICK_RATE_W'(RATE_MAX);
        phase_rate[1] = TICK_RATE_W'(1);
        phase_rate[2] = '0;
        phase_rate[3] = TICK_RATE_W'($urandom_range(RATE_MAX, 2));
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed, reset tick rate
        send_request(ACT_TICK, 16'h0000, 32'h0000_0000);
        send_request(ACT_TICKS, 16'h0000, 32'h0000_0000);
        send_request(ACT_TICKS, 16'hFFFF, 32'hFFFF_FFFF);
        send_request(ACT_SEC, 16'h1234, 32'h0000_0000);
        send_request(ACT_SEC, 16'hA5A5, 32'h0000_0001);
        send_request(ACT_USEC, 16'h5A5A, 32'd55555);
        send_request(ACT_USEC, 16'h0007, 32'd55556);
        send_request(ACT_TICKS, 16'h0007, 32'h0000_0001);
        send_request(ACT_TICK, 16'hFFFF, 32'hFFFF_FFFF);
        for (int i = 0; i < SLOTS - 2; i++)
            send_request(ACT_TICKS, PID_W'(16'h0100 + i), AMOUNT_W'(i % 4));
        send_request(ACT_TICKS, 16'hBEEF, 32'h0000_0002);
        send_request(ACT_USEC, 16'hCAFE, 32'h0000_0001);
        send_request(ACT_TICK, 16'h0000, 32'h0000_0000);
        drain();

        for (int p = 0; p < 4; p++)
        begin
            write_rate(phase_rate[p]);
            no_idle = (p == 1);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (p == 0 && n == 3)
                    hold_req = 1'b1;
                if (p == 2 && n == ITEMS_PER_PHASE / 2)
                    drain();
                send_random(phase_rate[p]);
            end
            drain();
        end
        no_idle = 1'b0;

        $display("Covered %0d transactions over tick rates 18, %0d, 1, 0 and %0d.",
                 sb.requests, RATE_MAX, phase_rate[3]);
        $display("Reports: %0d woken, %0d accepted, %0d zero wait, %0d table full, %0d idle ticks.",
                 sb.kind_seen[KIND_WOKEN], sb.kind_seen[KIND_ACCEPTED], sb.kind_seen[KIND_ZERO],
                 sb.kind_seen[KIND_FULL], sb.kind_seen[KIND_NONE]);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("tb_sleep_wakeup_timer_table_core: PASS");
        else
            $display("tb_sleep_wakeup_timer_table_core: FAIL");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+design
design/swt_pkg.sv
design/swt_front.sv
design/swt_fifo.sv
design/swt_back.sv
design/sleep_wakeup_timer_table_core.sv
design/swt_props.sv
verif/tb_sleep_wakeup_timer_table_core.sv
